[rtl/core/lcs_pkg.sv]
// Shared types and constants for the longest common subsequence engine.
// No dependencies.
package lcs_pkg;
  localparam int SYM_W = 8;
  localparam int LEN_W = 6;

  typedef logic [1:0] cmd_t;
  typedef logic [1:0] dir_t;

  localparam cmd_t CMD_LOAD_A  = 2'd0;
  localparam cmd_t CMD_LOAD_B  = 2'd1;
  localparam cmd_t CMD_COMPUTE = 2'd2;
  localparam cmd_t CMD_UNUSED  = 2'd3;

  localparam dir_t DIR_DIAG = 2'd1;
  localparam dir_t DIR_UP   = 2'd2;
  localparam dir_t DIR_LEFT = 2'd3;
endpackage

[rtl/core/lcs_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module lcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/lcs_length_and_traceback.sv]
// Top level of the longest common subsequence engine.
// Depends on lcs_pkg and lcs_ram.
//
// The input channel takes one transfer per command: in_tuser carries the
// command and in_tdata the symbol. Load commands append a symbol to the first
// or second string; symbols beyond MAX_LEN are dropped and the overflow flag
// is set. A compute command fills the score row and the direction table, each
// cell through a read and a write state, traces back from the corner, each
// step through a read and an evaluate state, and then emits the subsequence
// symbols in forward order, each through a read and a load state, followed by
// one transfer with tlast set that carries the length and a zero symbol.
// Every result transfer carries the length and the overflow flag. Compute
// then clears both string lengths and the flag. The block takes no input
// while a compute is in progress. A stalled receiver holds the output
// register and the sequencer waits; loads are accepted while the final
// transfer still waits. Reset clears the counts, the flag and the sequencer;
// the string, score, direction and reversal stores are not cleared.
module lcs_length_and_traceback
  import lcs_pkg::*;
#(
  parameter int MAX_LEN = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // symbol[7:0]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // out_symbol[7:0], length[13:8], overflow[14], zero[15]
  output logic        out_tlast
);
  localparam int CW  = $clog2(MAX_LEN + 1);
  localparam int AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int DAW = (MAX_LEN * MAX_LEN > 1) ? $clog2(MAX_LEN * MAX_LEN) : 1;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_FILL_RD = 3'd1;
  localparam logic [2:0] S_FILL_WR = 3'd2;
  localparam logic [2:0] S_TB_RD   = 3'd3;
  localparam logic [2:0] S_TB_EV   = 3'd4;
  localparam logic [2:0] S_EM_RD   = 3'd5;
  localparam logic [2:0] S_EM_LD   = 3'd6;
  localparam logic [2:0] S_FIN     = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [CW-1:0]    cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic             drop_r, drop_nxt;
  logic [CW-1:0]    i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [LEN_W-1:0] diag_r, diag_nxt, left_r, left_nxt, len_r, len_nxt;
  logic             out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  logic [SYM_W-1:0] out_sym_r, out_sym_nxt;
  logic [LEN_W-1:0] out_len_r, out_len_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  logic             a_we, b_we, s_we, d_we, r_we;
  logic [SYM_W-1:0] a_rdata, b_rdata, r_rdata;
  logic [LEN_W-1:0] s_rdata;
  dir_t             d_rdata, dir_w;
  logic [LEN_W-1:0] up, score_new;
  logic [DAW-1:0]   d_addr;
  logic             out_free, in_xfer;
  cmd_t             cmd;

  assign cmd      = in_tuser;
  assign in_xfer  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign d_addr   = DAW'(32'(i_r - CW'(1)) * MAX_LEN + 32'(j_r - CW'(1)));
  assign up       = (i_r == CW'(1)) ? '0 : s_rdata;

  always_comb begin
    if (a_rdata == b_rdata) begin
      score_new = diag_r + LEN_W'(1);
      dir_w     = DIR_DIAG;
    end else if (up >= left_r) begin
      score_new = up;
      dir_w     = DIR_UP;
    end else begin
      score_new = left_r;
      dir_w     = DIR_LEFT;
    end
  end

  lcs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_str_a (
    .clk(clk), .we(a_we), .waddr(AW'(cnt_a_r)), .wdata(in_tdata),
    .raddr(AW'(i_r - CW'(1))), .rdata(a_rdata)
  );
  lcs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_str_b (
    .clk(clk), .we(b_we), .waddr(AW'(cnt_b_r)), .wdata(in_tdata),
    .raddr(AW'(j_r - CW'(1))), .rdata(b_rdata)
  );
  lcs_ram #(.WIDTH(LEN_W), .DEPTH(MAX_LEN + 1)) u_score (
    .clk(clk), .we(s_we), .waddr(j_r), .wdata(score_new),
    .raddr(j_r), .rdata(s_rdata)
  );
  lcs_ram #(.WIDTH(2), .DEPTH(MAX_LEN * MAX_LEN)) u_dir (
    .clk(clk), .we(d_we), .waddr(d_addr), .wdata(dir_w),
    .raddr(d_addr), .rdata(d_rdata)
  );
  lcs_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_rev (
    .clk(clk), .we(r_we), .waddr(AW'(k_r)), .wdata(a_rdata),
    .raddr(AW'(k_r - CW'(1))), .rdata(r_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_a_nxt     = cnt_a_r;
    cnt_b_nxt     = cnt_b_r;
    drop_nxt      = drop_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    diag_nxt      = diag_r;
    left_nxt      = left_r;
    len_nxt       = len_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_sym_nxt   = out_sym_r;
    out_len_nxt   = out_len_r;
    out_ovf_nxt   = out_ovf_r;
    out_last_nxt  = out_last_r;
    a_we = 1'b0;
    b_we = 1'b0;
    s_we = 1'b0;
    d_we = 1'b0;
    r_we = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (cmd)
            CMD_LOAD_A: begin
              if (cnt_a_r < CW'(MAX_LEN)) begin
                a_we      = 1'b1;
                cnt_a_nxt = cnt_a_r + CW'(1);
              end else begin
                drop_nxt = 1'b1;
              end
            end
            CMD_LOAD_B: begin
              if (cnt_b_r < CW'(MAX_LEN)) begin
                b_we      = 1'b1;
                cnt_b_nxt = cnt_b_r + CW'(1);
              end else begin
                drop_nxt = 1'b1;
              end
            end
            CMD_COMPUTE: begin
              k_nxt    = '0;
              i_nxt    = CW'(1);
              j_nxt    = CW'(1);
              diag_nxt = '0;
              left_nxt = '0;
              if (cnt_a_r == '0 || cnt_b_r == '0) begin
                len_nxt   = '0;
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_FILL_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_FILL_RD: state_nxt = S_FILL_WR;
      S_FILL_WR: begin
        s_we = 1'b1;
        d_we = 1'b1;
        if (j_r == cnt_b_r) begin
          if (i_r == cnt_a_r) begin
            len_nxt   = score_new;
            state_nxt = S_TB_RD;
          end else begin
            i_nxt     = i_r + CW'(1);
            j_nxt     = CW'(1);
            diag_nxt  = '0;
            left_nxt  = '0;
            state_nxt = S_FILL_RD;
          end
        end else begin
          j_nxt     = j_r + CW'(1);
          diag_nxt  = up;
          left_nxt  = score_new;
          state_nxt = S_FILL_RD;
        end
      end
      S_TB_RD: state_nxt = S_TB_EV;
      S_TB_EV: begin
        if (d_rdata == DIR_DIAG) begin
          r_we  = 1'b1;
          k_nxt = k_r + CW'(1);
          i_nxt = i_r - CW'(1);
          j_nxt = j_r - CW'(1);
        end else if (d_rdata == DIR_UP) begin
          i_nxt = i_r - CW'(1);
        end else begin
          j_nxt = j_r - CW'(1);
        end
        if (i_nxt == '0 || j_nxt == '0) begin
          state_nxt = (k_nxt != '0) ? S_EM_RD : S_FIN;
        end else begin
          state_nxt = S_TB_RD;
        end
      end
      S_EM_RD: state_nxt = S_EM_LD;
      S_EM_LD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = r_rdata;
          out_len_nxt   = len_r;
          out_ovf_nxt   = drop_r;
          out_last_nxt  = 1'b0;
          k_nxt         = k_r - CW'(1);
          state_nxt     = (k_r == CW'(1)) ? S_FIN : S_EM_RD;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sym_nxt   = '0;
          out_len_nxt   = len_r;
          out_ovf_nxt   = drop_r;
          out_last_nxt  = 1'b1;
          cnt_a_nxt     = '0;
          cnt_b_nxt     = '0;
          drop_nxt      = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    diag_r     <= diag_nxt;
    left_r     <= left_nxt;
    len_r      <= len_nxt;
    out_sym_r  <= out_sym_nxt;
    out_len_r  <= out_len_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_ovf_r, out_len_r, out_sym_r};
  assign out_tlast  = out_last_r;

  a_final_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[7:0] == '0)
    else $error("final transfer carries a nonzero symbol");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_a_r <= CW'(MAX_LEN) && cnt_b_r <= CW'(MAX_LEN))
    else $error("string count beyond capacity");
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FILL_WR |-> j_r != '0 && j_r <= cnt_b_r && i_r != '0 && i_r <= cnt_a_r)
    else $error("fill index out of range");
  a_fin_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && out_free |=> cnt_a_r == '0 && cnt_b_r == '0 && !drop_r)
    else $error("compute did not clear the string state");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_sym_r) && $stable(out_last_r))
    else $error("stalled result changed");
endmodule
